// File: rtl/lzssw_pkg.sv
package lzssw_pkg;

	// Window geometry: 8 KiB of history, byte wide
	localparam int WIN_AW    = 13;
	localparam int MIN_MATCH = 3;

	// Defaults for the token field widths
	localparam int OFFSET_BITS_DEF = 13;
	localparam int LENGTH_BITS_DEF = 4;

	// Entries in the command queue between decoder and copy engine
	localparam int QUEUE_DEPTH = 2;

	// What one input byte asks the copy engine to do
	typedef enum logic [1:0] {
		CMD_NOP  = 2'd0,
		CMD_LIT  = 2'd1,
		CMD_EOS  = 2'd2,
		CMD_COPY = 2'd3
	} cmd_kind_t;

endpackage

// File: rtl/lzssw_front.sv
module lzssw_front #(
	parameter int OFFSET_BITS = lzssw_pkg::OFFSET_BITS_DEF,
	parameter int LENGTH_BITS = lzssw_pkg::LENGTH_BITS_DEF,
	parameter int CMD_W       = 11 + OFFSET_BITS + LENGTH_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       in_byte,
	input  logic             stream_start,
	output logic             cmd_push,
	input  logic             cmd_space,
	output logic [CMD_W-1:0] cmd_data
);

	// Pending bits are kept left aligned: the oldest bit is the MSB
	localparam int PW  = OFFSET_BITS + LENGTH_BITS + 8;
	localparam int CW  = $clog2(PW + 1);
	localparam int TOK = 1 + OFFSET_BITS + LENGTH_BITS;

	localparam logic [CW-1:0] LIT_BITS  = CW'(9);
	localparam logic [CW-1:0] EOS_BITS  = CW'(1 + OFFSET_BITS);
	localparam logic [CW-1:0] COPY_BITS = CW'(TOK);
	localparam logic [CW-1:0] BYTE_BITS = CW'(8);

	typedef struct packed {
		lzssw_pkg::cmd_kind_t   kind;
		logic                   restart;
		logic [7:0]             lit;
		logic [OFFSET_BITS-1:0] pos;
		logic [LENGTH_BITS-1:0] len;
	} cmd_t;

	logic [PW-1:0] pend_q;
	logic [CW-1:0] cnt_q;
	logic          fin_q;

	logic [PW-1:0] base_bits, merged, pend_d;
	logic [CW-1:0] base_cnt, ncnt, cnt_d;
	logic          base_fin, fin_d;
	logic          flag, lit_ok, eos_ok, copy_ok, accept;
	logic [OFFSET_BITS-1:0] pos;
	cmd_t          cmd;

	assign in_ready = cmd_space;
	assign accept   = in_valid & in_ready;

	// Restart empties the bit reader before the new byte goes in
	always_comb begin
		base_bits = stream_start ? '0 : pend_q;
		base_cnt  = stream_start ? '0 : cnt_q;
		base_fin  = stream_start ? 1'b0 : fin_q;
		merged    = base_bits | ({in_byte, {(PW-8){1'b0}}} >> base_cnt);
		ncnt      = base_cnt + BYTE_BITS;
		flag      = merged[PW-1];
		pos       = merged[PW-2 -: OFFSET_BITS];
		lit_ok    = !base_fin && flag && (ncnt >= LIT_BITS);
		eos_ok    = !base_fin && !flag && (ncnt >= EOS_BITS) && (pos == '0);
		copy_ok   = !base_fin && !flag && (ncnt >= COPY_BITS) && (pos != '0);
	end

	// Next bit reader state: at most one token completes per byte
	always_comb begin
		pend_d = merged;
		cnt_d  = ncnt;
		fin_d  = base_fin;
		if (base_fin) begin
			pend_d = base_bits;
			cnt_d  = base_cnt;
		end else if (lit_ok) begin
			pend_d = merged << 9;
			cnt_d  = ncnt - LIT_BITS;
		end else if (eos_ok) begin
			pend_d = '0;
			cnt_d  = '0;
			fin_d  = 1'b1;
		end else if (copy_ok) begin
			pend_d = merged << TOK;
			cnt_d  = ncnt - COPY_BITS;
		end
	end

	// Command for the copy engine
	always_comb begin
		cmd.restart = stream_start;
		cmd.lit     = merged[PW-2 -: 8];
		cmd.pos     = pos;
		cmd.len     = merged[PW-2-OFFSET_BITS -: LENGTH_BITS];
		if (lit_ok) begin
			cmd.kind = lzssw_pkg::CMD_LIT;
		end else if (eos_ok) begin
			cmd.kind = lzssw_pkg::CMD_EOS;
		end else if (copy_ok) begin
			cmd.kind = lzssw_pkg::CMD_COPY;
		end else begin
			cmd.kind = lzssw_pkg::CMD_NOP;
		end
	end

	assign cmd_data = cmd;
	assign cmd_push = accept && (stream_start || lit_ok || eos_ok || copy_ok);

	// Bit reader registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			cnt_q  <= '0;
			fin_q  <= 1'b0;
		end else if (accept) begin
			pend_q <= pend_d;
			cnt_q  <= cnt_d;
			fin_q  <= fin_d;
		end
	end

endmodule

// File: rtl/lzssw_cmd_fifo.sv
module lzssw_cmd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = lzssw_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             space,
	input  logic             pop,
	output logic             avail,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] fill_q;
	logic             do_push, do_pop;

	assign space    = (fill_q != CNT_W'(DEPTH));
	assign avail    = (fill_q != '0);
	assign do_push  = push && space;
	assign do_pop   = pop && avail;
	assign pop_data = slot_q[rd_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/lzssw_back.sv
module lzssw_back #(
	parameter int OFFSET_BITS = lzssw_pkg::OFFSET_BITS_DEF,
	parameter int LENGTH_BITS = lzssw_pkg::LENGTH_BITS_DEF,
	parameter int CMD_W       = 11 + OFFSET_BITS + LENGTH_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_avail,
	input  logic [CMD_W-1:0] cmd_data,
	output logic             cmd_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic             out_last,
	output logic             out_eos
);

	localparam int AW    = lzssw_pkg::WIN_AW;
	localparam int DEPTH = 1 << AW;
	localparam int RW    = LENGTH_BITS + 1;

	typedef struct packed {
		lzssw_pkg::cmd_kind_t   kind;
		logic                   restart;
		logic [7:0]             lit;
		logic [OFFSET_BITS-1:0] pos;
		logic [LENGTH_BITS-1:0] len;
	} cmd_t;

	cmd_t cmd;
	assign cmd = cmd_data;

	// Window memory
	logic [7:0] win_q [DEPTH];
	logic [7:0] rd_data_q;

	// Active command
	logic                 act_q;
	lzssw_pkg::cmd_kind_t kind_q;
	logic [7:0]           lit_q;
	logic [AW-1:0]        ra_q;
	logic [RW-1:0]        rem_q;
	logic [AW-1:0]        ip_q;

	// Written-region tracking: entries 1..hi_q, and entry 0 once wrapped
	logic [AW-1:0]        hi_q;
	logic                 zero_wr_q;

	// Read/emit stage
	logic                 s1_v_q;
	logic                 s1_mem_s1, s1_fwd_s1, s1_known_s1, s1_wr_s1;
	logic                 s1_last_s1, s1_eos_s1;
	logic [7:0]           s1_lit_s1, s1_fdata_s1;
	logic [AW-1:0]        s1_waddr_s1;

	// Output register
	logic                 out_v_q;
	logic [7:0]           out_byte_q;
	logic                 out_last_q, out_eos_q;

	logic       s1_adv, s1_free, issue, last_iss, we, fwd, hit;
	logic [7:0] s1_byte;

	assign s1_adv   = s1_v_q && (!out_v_q || out_ready);
	assign s1_free  = !s1_v_q || s1_adv;
	assign issue    = act_q && s1_free;
	assign last_iss = issue && (rem_q == RW'(1));
	assign cmd_pop  = cmd_avail && (!act_q || last_iss);
	assign we       = s1_adv && s1_wr_s1;
	assign fwd      = we && (s1_waddr_s1 == ra_q);
	assign hit      = (ra_q != '0) ? (ra_q <= hi_q) : zero_wr_q;

	// Byte held in the emit stage
	always_comb begin
		if (!s1_mem_s1) begin
			s1_byte = s1_lit_s1;
		end else if (s1_fwd_s1) begin
			s1_byte = s1_fdata_s1;
		end else if (s1_known_s1) begin
			s1_byte = rd_data_q;
		end else begin
			s1_byte = '0;
		end
	end

	// Window write on emit, registered read on issue
	always_ff @(posedge clk) begin
		if (we) begin
			win_q[s1_waddr_s1] <= s1_byte;
		end
		if (issue) begin
			rd_data_q <= win_q[ra_q];
		end
	end

	// Command sequencing and write pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			kind_q <= lzssw_pkg::CMD_NOP;
			lit_q  <= '0;
			ra_q   <= '0;
			rem_q  <= '0;
			ip_q   <= AW'(1);
		end else begin
			if (cmd_pop) begin
				act_q  <= (cmd.kind != lzssw_pkg::CMD_NOP);
				kind_q <= cmd.kind;
				lit_q  <= cmd.lit;
				ra_q   <= AW'(cmd.pos);
				rem_q  <= (cmd.kind == lzssw_pkg::CMD_COPY) ?
				          RW'(cmd.len) + RW'(lzssw_pkg::MIN_MATCH) : RW'(1);
			end else if (issue) begin
				ra_q  <= ra_q + 1'b1;
				rem_q <= rem_q - 1'b1;
				if (last_iss) begin
					act_q <= 1'b0;
				end
			end
			// restart wins over the last byte of the previous command
			if (cmd_pop && cmd.restart) begin
				ip_q <= AW'(1);
			end else if (issue && (kind_q != lzssw_pkg::CMD_EOS)) begin
				ip_q <= ip_q + 1'b1;
			end
		end
	end

	// High-water mark of written window entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q      <= '0;
			zero_wr_q <= 1'b0;
		end else if (we) begin
			if (s1_waddr_s1 == '0) begin
				zero_wr_q <= 1'b1;
			end else if (s1_waddr_s1 > hi_q) begin
				hi_q <= s1_waddr_s1;
			end
		end
	end

	// Emit stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (issue) begin
			s1_v_q <= 1'b1;
		end else if (s1_adv) begin
			s1_v_q <= 1'b0;
		end
	end

	// Emit stage payload; a same-cycle write to the read address is forwarded
	always_ff @(posedge clk) begin
		if (issue) begin
			s1_mem_s1   <= (kind_q == lzssw_pkg::CMD_COPY);
			s1_fwd_s1   <= fwd;
			s1_fdata_s1 <= s1_byte;
			s1_known_s1 <= fwd || hit;
			s1_lit_s1   <= (kind_q == lzssw_pkg::CMD_LIT) ? lit_q : '0;
			s1_wr_s1    <= (kind_q != lzssw_pkg::CMD_EOS);
			s1_waddr_s1 <= ip_q;
			s1_last_s1  <= (rem_q == RW'(1));
			s1_eos_s1   <= (kind_q == lzssw_pkg::CMD_EOS);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_adv) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_byte_q <= s1_byte;
			out_last_q <= s1_last_s1;
			out_eos_q  <= s1_eos_s1;
		end
	end

	assign out_valid = out_v_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;
	assign out_eos   = out_eos_q;

`ifndef NO_ASSERTIONS
	a_rem_live: assert property (@(posedge clk) disable iff (!arst_n)
		act_q |-> (rem_q != '0))
		else $error("active command with no bytes left");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (!s1_v_q || s1_adv))
		else $error("read issued over a held emit stage");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v_q && !s1_adv) |=> (s1_v_q && $stable(s1_waddr_s1)))
		else $error("stalled emit stage lost its byte");

	a_eos_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_eos_q) |-> (out_last_q && (out_byte_q == '0)))
		else $error("end marker result malformed");
`endif

endmodule

// File: rtl/lzss_window_decompressor.sv
// Channel  Dir  tdata                   tuser             tlast
// s_axis   in   [7:0] in_byte           [0] stream_start  -
// m_axis   out  [7:0] out_byte          [0] end_of_stream last_of_run
//
// Literals and end markers pass queue, command, emit and output regs; a copy
// emits count+3 bytes, one per cycle, paced by the single window read port.
// The decoder takes a byte per cycle while the command queue has room.
// arst_n clears the bit reader, the queue and the engine; the window needs
// no clearing pass, entries never written read as zero.
// Backpressure on m_axis stalls the copy engine, then the queue, then s_axis.
module lzss_window_decompressor #(
	parameter int OFFSET_BITS = lzssw_pkg::OFFSET_BITS_DEF,
	parameter int LENGTH_BITS = lzssw_pkg::LENGTH_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tuser,   // [0] stream_start
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic       m_axis_tuser,   // [0] end_of_stream
	output logic       m_axis_tlast
);

	localparam int CMD_W = 11 + OFFSET_BITS + LENGTH_BITS;

	logic             push, space, pop, avail;
	logic [CMD_W-1:0] push_data, pop_data;

	// Bit reader and token decode
	lzssw_front #(
		.OFFSET_BITS (OFFSET_BITS),
		.LENGTH_BITS (LENGTH_BITS),
		.CMD_W       (CMD_W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_byte      (s_axis_tdata),
		.stream_start (s_axis_tuser),
		.cmd_push     (push),
		.cmd_space    (space),
		.cmd_data     (push_data)
	);

	// Command queue
	lzssw_cmd_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (lzssw_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.space     (space),
		.pop       (pop),
		.avail     (avail),
		.pop_data  (pop_data)
	);

	// Window copy engine
	lzssw_back #(
		.OFFSET_BITS (OFFSET_BITS),
		.LENGTH_BITS (LENGTH_BITS),
		.CMD_W       (CMD_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_avail (avail),
		.cmd_data  (pop_data),
		.cmd_pop   (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_eos   (m_axis_tuser)
	);

endmodule

// File: tb/sv/lzss_window_decompressor_tb.sv
`timescale 1ns / 1ps

module lzss_window_decompressor_tb;

	localparam int OFF_W      = lzssw_pkg::OFFSET_BITS_DEF;
	localparam int LEN_W      = lzssw_pkg::LENGTH_BITS_DEF;
	localparam int WIN_SIZE   = 1 << lzssw_pkg::WIN_AW;
	localparam int MAX_BEATS  = (1 << LEN_W) - 1 + lzssw_pkg::MIN_MATCH;
	localparam int N_BYTES    = 480;
	localparam int QUIET_TAIL = 60;
	localparam int HOLD_AT    = 150;
	localparam int HOLD_LEN   = 300;
	localparam int LIMIT      = 1000000;

	typedef struct packed {
		logic [7:0] data;
		logic       st;
	} in_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       eos;
	} out_beat_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic       s_axis_tuser;
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tuser;
	logic       m_axis_tlast;

	lzss_window_decompressor u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always #4 clk = ~clk;

	// Compressed bytes waiting to be sent, decoded bytes waiting to be seen
	in_item_t  byte_q[$];
	out_beat_t decoded_q[$];

	int n_err   = 0;
	int n_taken = 0;
	int cyc     = 0;
	logic in_xfer = 1'b0;

	// ---------------------------------------------------------------
	// Decoder mirror: window, write pointer, bit reader, finished flag
	// ---------------------------------------------------------------
	logic [7:0]  hist [0:WIN_SIZE-1];
	logic [12:0] hist_wp;
	logic [31:0] bit_buf;
	int          bit_cnt;
	logic        stream_done;

	task automatic decode_byte(input logic [7:0] din, input logic st);
		out_beat_t   beats [0:MAX_BEATS-1];
		int          nb;
		int          run_len;
		int          i;
		logic [31:0] tmp;
		logic [12:0] pos;
		logic [7:0]  v;
		nb = 0;
		if (st) begin
			bit_buf     = '0;
			bit_cnt     = 0;
			hist_wp     = 13'd1;
			stream_done = 1'b0;
		end
		if (stream_done)
			return;
		bit_buf = (bit_buf << 8) | {24'd0, din};
		bit_cnt += 8;
		while (bit_cnt >= 1) begin
			if (bit_buf[bit_cnt-1]) begin
				// literal: flag + 8 bits
				if (bit_cnt < 9)
					break;
				tmp = bit_buf >> (bit_cnt - 9);
				v = tmp[7:0];
				bit_cnt -= 9;
				bit_buf &= (32'd1 << bit_cnt) - 1;
				hist[hist_wp] = v;
				hist_wp++;
				beats[nb] = '{data: v, last: 1'b0, eos: 1'b0};
				nb++;
			end else begin
				if (bit_cnt < 1 + OFF_W)
					break;
				tmp = bit_buf >> (bit_cnt - 1 - OFF_W);
				pos = tmp[OFF_W-1:0];
				// position zero is the end marker; leftover bits are dropped
				if (pos == 0) begin
					beats[nb] = '{data: 8'h00, last: 1'b0, eos: 1'b1};
					nb++;
					stream_done = 1'b1;
					bit_buf     = '0;
					bit_cnt     = 0;
					break;
				end
				if (bit_cnt < 1 + OFF_W + LEN_W)
					break;
				tmp = bit_buf >> (bit_cnt - 1 - OFF_W - LEN_W);
				run_len = int'(tmp[LEN_W-1:0]) + lzssw_pkg::MIN_MATCH;
				bit_cnt -= 1 + OFF_W + LEN_W;
				bit_buf &= (32'd1 << bit_cnt) - 1;
				// byte-wise copy, so overlap repeats freshly written bytes
				for (i = 0; i < run_len; i++) begin
					v = hist[pos + 13'(i)];
					hist[hist_wp] = v;
					hist_wp++;
					beats[nb] = '{data: v, last: 1'b0, eos: 1'b0};
					nb++;
				end
			end
		end
		for (i = 0; i < nb; i++) begin
			if (i == nb - 1)
				beats[i].last = 1'b1;
			decoded_q.push_back(beats[i]);
		end
	endtask

	// ---------------------------------------------------------------
	// Stream builder: tokens go into a bit list, then are packed MSB first
	// ---------------------------------------------------------------
	bit          tok_bits[$];
	logic        next_start;
	logic [12:0] gen_wp;
	int          n_useful = 0;

	task automatic put_bits(input int n, input logic [15:0] v);
		int i;
		for (i = n - 1; i >= 0; i--)
			tok_bits.push_back(v[i]);
	endtask

	task automatic open_stream();
		tok_bits.delete();
		next_start = 1'b1;
		gen_wp     = 13'd1;
	endtask

	task automatic put_token(input lzssw_pkg::cmd_kind_t kind, input logic [12:0] pos,
			input logic [3:0] len, input logic [7:0] lit);
		case (kind)
			lzssw_pkg::CMD_LIT: begin
				put_bits(1, 16'd1);
				put_bits(8, 16'(lit));
				gen_wp++;
			end
			lzssw_pkg::CMD_COPY: begin
				put_bits(1, 16'd0);
				put_bits(OFF_W, 16'(pos));
				put_bits(LEN_W, 16'(len));
				gen_wp += 13'(len + lzssw_pkg::MIN_MATCH);
			end
			lzssw_pkg::CMD_EOS: begin
				put_bits(1, 16'd0);
				put_bits(OFF_W, 16'd0);
			end
			default: ;
		endcase
	endtask

	// pad the tail with random bits and queue the bytes
	task automatic flush_stream();
		logic [7:0] b8;
		int i;
		while (tok_bits.size() % 8 != 0)
			tok_bits.push_back(1'($urandom_range(0, 1)));
		while (tok_bits.size() != 0) begin
			for (i = 7; i >= 0; i--)
				b8[i] = tok_bits.pop_front();
			byte_q.push_back('{data: b8, st: next_start});
			next_start = 1'b0;
			n_useful++;
		end
	endtask

	task automatic push_raw(input logic [7:0] b8, input logic st);
		byte_q.push_back('{data: b8, st: st});
		n_useful++;
	endtask

	// copy source: mostly just behind the write pointer, sometimes anywhere
	function automatic logic [12:0] pick_pos();
		logic [12:0] pos;
		if ($urandom_range(0, 3) != 0)
			pos = gen_wp - 13'($urandom_range(1, 20));
		else
			pos = 13'($urandom_range(1, WIN_SIZE - 1));
		if (pos == 0)
			pos = 13'h1fff;
		return pos;
	endfunction

	task automatic build_stimulus();
		int n_tok;
		int i;
		int k;
		logic ended;
		// literal extremes, shortest and longest copy, overlap, unwritten
		// window entries, end marker, then bytes ignored after the end
		open_stream();
		put_token(lzssw_pkg::CMD_LIT, '0, '0, 8'h00);
		put_token(lzssw_pkg::CMD_LIT, '0, '0, 8'hff);
		put_token(lzssw_pkg::CMD_COPY, 13'd1, 4'd0, '0);
		put_token(lzssw_pkg::CMD_COPY, gen_wp - 13'd1, 4'hf, '0);
		put_token(lzssw_pkg::CMD_COPY, 13'h1fff, 4'hf, '0);
		put_token(lzssw_pkg::CMD_LIT, '0, '0, 8'ha5);
		put_token(lzssw_pkg::CMD_EOS, '0, '0, '0);
		flush_stream();
		push_raw(8'hff, 1'b0);
		push_raw(8'h80, 1'b0);
		// all-zero stream: end marker on its second byte
		push_raw(8'h00, 1'b1);
		push_raw(8'h00, 1'b0);
		push_raw(8'hc3, 1'b0);
		// restart in the middle of a copy token
		open_stream();
		put_token(lzssw_pkg::CMD_LIT, '0, '0, 8'h3c);
		put_token(lzssw_pkg::CMD_COPY, 13'd1, 4'd2, '0);
		put_bits(1, 16'd0);
		put_bits(9, 16'h1ab);
		flush_stream();

		// random part
		while (n_useful < N_BYTES) begin
			if ($urandom_range(0, 9) == 0) begin
				// noise stream
				n_tok = $urandom_range(1, 6);
				for (i = 0; i < n_tok; i++)
					push_raw(8'($urandom), i == 0);
			end else begin
				open_stream();
				n_tok = $urandom_range(1, 30);
				for (i = 0; i < n_tok; i++) begin
					if ($urandom_range(0, 9) < 5)
						put_token(lzssw_pkg::CMD_LIT, '0, '0, 8'($urandom));
					else
						put_token(lzssw_pkg::CMD_COPY, pick_pos(), 4'($urandom), '0);
				end
				ended = ($urandom_range(0, 7) != 0);
				if (ended)
					put_token(lzssw_pkg::CMD_EOS, '0, '0, '0);
				else
					put_bits($urandom_range(1, 12), 16'($urandom));
				flush_stream();
				if (ended && $urandom_range(0, 2) == 0) begin
					k = $urandom_range(1, 3);
					for (i = 0; i < k; i++)
						push_raw(8'($urandom), 1'b0);
				end
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Sender: one compressed byte per transfer, random idle bursts
	// ---------------------------------------------------------------
	int drv_gap  = 0;
	int drv_rate = 0;

	always @(negedge clk) begin
		in_item_t it;
		logic     v;
		if (arst_n) begin
			if (cyc % 64 == 0)
				drv_rate = $urandom_range(0, 3);
			if (!s_axis_tvalid || in_xfer) begin
				v = 1'b0;
				if (drv_gap > 0)
					drv_gap--;
				else if (byte_q.size() >= QUIET_TAIL && drv_rate != 0 &&
						$urandom_range(0, 15) < drv_rate)
					drv_gap = $urandom_range(0, 13);
				else if (byte_q.size() != 0) begin
					it = byte_q.pop_front();
					v  = 1'b1;
					s_axis_tdata <= it.data;
					s_axis_tuser <= it.st;
				end
				s_axis_tvalid <= v;
			end
		end
	end

	// ---------------------------------------------------------------
	// Receiver: random stall bursts plus one long hold-off
	// ---------------------------------------------------------------
	int   rcv_stall = 0;
	int   rcv_rate  = 0;
	int   hold_cnt  = 0;
	logic hold_done = 1'b0;

	always @(negedge clk) begin
		logic rdy;
		if (arst_n) begin
			if (cyc % 64 == 32)
				rcv_rate = $urandom_range(0, 3);
			if (!hold_done && n_taken >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_cnt  = HOLD_LEN;
			end
			rdy = 1'b0;
			if (hold_cnt > 0)
				hold_cnt--;
			else if (rcv_stall > 0)
				rcv_stall--;
			else if (byte_q.size() >= QUIET_TAIL && rcv_rate != 0 &&
					$urandom_range(0, 15) < rcv_rate)
				rcv_stall = $urandom_range(0, 13);
			else
				rdy = 1'b1;
			m_axis_tready <= rdy;
		end
	end

	// ---------------------------------------------------------------
	// Predict on each input transfer, check each output transfer
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		out_beat_t e;
		in_xfer <= s_axis_tvalid && s_axis_tready;
		if (s_axis_tvalid && s_axis_tready) begin
			decode_byte(s_axis_tdata, s_axis_tuser);
			n_taken++;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			if (decoded_q.size() == 0) begin
				$display("%0t: unexpected output data %02h last %0b eos %0b",
					$time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
				n_err++;
			end else begin
				e = decoded_q.pop_front();
				if (m_axis_tdata !== e.data || m_axis_tlast !== e.last ||
						m_axis_tuser !== e.eos) begin
					$display("%0t: output mismatch: expected data %02h last %0b eos %0b, got data %02h last %0b eos %0b",
						$time, e.data, e.last, e.eos,
						m_axis_tdata, m_axis_tlast, m_axis_tuser);
					n_err++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cyc++;
		if (cyc == LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Reset, stimulus, end of run
	// ---------------------------------------------------------------
	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		m_axis_tready = 1'b0;
		for (int i = 0; i < WIN_SIZE; i++)
			hist[i] = '0;
		hist_wp     = 13'd1;
		bit_buf     = '0;
		bit_cnt     = 0;
		stream_done = 1'b0;
		build_stimulus();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (byte_q.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (4 * MAX_BEATS) @(posedge clk);
		if (n_err == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: filelist.f
rtl/lzssw_pkg.sv
rtl/lzssw_front.sv
rtl/lzssw_cmd_fifo.sv
rtl/lzssw_back.sv
rtl/lzss_window_decompressor.sv
tb/sv/lzss_window_decompressor_tb.sv
